// File: sv/psc_pkg.sv
package psc_pkg;

    // Kind of event carried in the input user field.
    typedef enum logic [1:0] {
        KIND_RX    = 2'd0,
        KIND_TX    = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    // Bank geometry: protocol counters first, then the transmit ICMP histogram.
    localparam int NPROTO    = 27;
    localparam int HIST_BASE = 27;
    localparam int READ_SPAN = 64;

    // Link and IP protocol codes.
    localparam logic [15:0] ET_IP         = 16'h0800;
    localparam logic [15:0] ET_ARP        = 16'h0806;
    localparam logic [15:0] ET_RARP       = 16'h8035;
    localparam logic [15:0] ET_PPPOE_DISC = 16'h8863;
    localparam logic [15:0] ET_PPPOE_SESS = 16'h8864;
    localparam logic [15:0] OP_ARP_REQ    = 16'd1;
    localparam logic [15:0] OP_ARP_REPLY  = 16'd2;
    localparam logic [15:0] OP_RARP_REQ   = 16'd3;
    localparam logic [15:0] OP_RARP_REPLY = 16'd4;
    localparam logic [7:0]  PR_ICMP       = 8'd1;
    localparam logic [7:0]  PR_IGMP       = 8'd2;
    localparam logic [7:0]  PR_TCP        = 8'd6;
    localparam logic [7:0]  PR_UDP        = 8'd17;

    // Offsets inside the seven link counters shared by receive and transmit.
    localparam int LK_NONIP      = 0;
    localparam int LK_ARP_REQ    = 1;
    localparam int LK_ARP_REPLY  = 2;
    localparam int LK_RARP_REQ   = 3;
    localparam int LK_RARP_REPLY = 4;
    localparam int LK_PPPOE_DISC = 5;
    localparam int LK_PPPOE_SESS = 6;
    localparam int LK_COUNT      = 7;

    // Counter addresses in the protocol bank.
    localparam int C_RX_BASE      = 0;
    localparam int C_RX_IP        = 7;
    localparam int C_RX_IGMP      = 8;
    localparam int C_RX_UDP       = 9;
    localparam int C_RX_TCP       = 10;
    localparam int C_TX_BASE      = 11;
    localparam int C_TX_RAW       = 18;
    localparam int C_TX_IGMP_RPT  = 19;
    localparam int C_TX_UDP       = 20;
    localparam int C_TX_TCP       = 21;
    localparam int C_TX_TCP_DATA  = 22;
    localparam int C_TX_TCP_BYTES = 23;
    localparam int C_TX_TCP_CTRL  = 24;
    localparam int C_TX_TCP_ACK   = 25;
    localparam int C_TX_TCP_URG   = 26;

    // One input beat, unpacked.
    typedef struct packed {
        t_kind       kind;
        logic [15:0] ethertype;
        logic [15:0] arp_opcode;
        logic [7:0]  ip_proto;
        logic [12:0] frag_offset;
        logic [3:0]  ip_hdr_words;
        logic [15:0] ip_total_len;
        logic [7:0]  icmp_type;
        logic [7:0]  igmp_type;
        logic [3:0]  tcp_data_offset;
        logic [7:0]  tcp_flags;
        logic [5:0]  counter_index;
    } t_item;

    // Update command from the classifier to the counter bank.
    typedef struct packed {
        logic [NPROTO-1:0] inc;
        logic [15:0]       byte_cnt;
        logic              hist_hit;
        logic [7:0]        icmp_type;
        logic              clear;
    } t_upd;

endpackage

// File: sv/psc_classify.sv
module psc_classify (
    input  psc_pkg::t_item i_item,
    input  logic           i_rarp_enable,
    input  logic           i_pppoe_enable,
    input  logic [7:0]     i_igmp_rpt_type,
    output psc_pkg::t_upd  o_upd
);
    import psc_pkg::*;

    logic                is_rx;
    logic                is_tx;
    logic                et_arp;
    logic                et_rarp;
    logic                et_pppoe;
    logic                et_ip;
    logic                et_other;
    logic [LK_COUNT-1:0] link;
    logic                tx_first;
    logic                tx_tcp;
    logic [6:0]          hdr_bytes;
    logic                has_data;
    logic [5:0]          flags;

    // Link-level classification, shared by both directions.
    always_comb begin
        is_rx    = (i_item.kind == KIND_RX);
        is_tx    = (i_item.kind == KIND_TX);
        et_arp   = (i_item.ethertype == ET_ARP);
        et_rarp  = i_rarp_enable && (i_item.ethertype == ET_RARP);
        et_pppoe = i_pppoe_enable && ((i_item.ethertype == ET_PPPOE_DISC) ||
                                      (i_item.ethertype == ET_PPPOE_SESS));
        et_ip    = (i_item.ethertype == ET_IP);
        et_other = !et_arp && !et_rarp && !et_pppoe && !et_ip;

        link                = '0;
        // PPPoE counts as non-IP only on the receive side.
        link[LK_NONIP]      = et_arp || et_rarp || et_other || (et_pppoe && is_rx);
        link[LK_ARP_REQ]    = et_arp && (i_item.arp_opcode == OP_ARP_REQ);
        link[LK_ARP_REPLY]  = et_arp && (i_item.arp_opcode == OP_ARP_REPLY);
        link[LK_RARP_REQ]   = et_rarp && (i_item.arp_opcode == OP_RARP_REQ);
        link[LK_RARP_REPLY] = et_rarp && (i_item.arp_opcode == OP_RARP_REPLY);
        link[LK_PPPOE_DISC] = et_pppoe && (i_item.ethertype == ET_PPPOE_DISC);
        link[LK_PPPOE_SESS] = et_pppoe && (i_item.ethertype == ET_PPPOE_SESS);
    end

    // TCP payload length: positive only when the headers fit in the total length.
    always_comb begin
        hdr_bytes = {1'b0, i_item.ip_hdr_words, 2'b00} + {1'b0, i_item.tcp_data_offset, 2'b00};
        has_data  = (i_item.ip_total_len > {9'd0, hdr_bytes});
        flags     = i_item.tcp_flags[5:0];
        tx_first  = is_tx && et_ip && (i_item.frag_offset == '0);
        tx_tcp    = tx_first && (i_item.ip_proto == PR_TCP);
    end

    // Build the update command.
    always_comb begin
        o_upd = '0;
        if (is_rx) begin
            o_upd.inc[C_RX_BASE +: LK_COUNT] = link;
        end
        if (is_tx) begin
            o_upd.inc[C_TX_BASE +: LK_COUNT] = link;
        end
        o_upd.inc[C_RX_IP]   = is_rx && et_ip;
        o_upd.inc[C_RX_IGMP] = is_rx && et_ip && (i_item.ip_proto == PR_IGMP);
        o_upd.inc[C_RX_UDP]  = is_rx && et_ip && (i_item.ip_proto == PR_UDP);
        o_upd.inc[C_RX_TCP]  = is_rx && et_ip && (i_item.ip_proto == PR_TCP);

        o_upd.inc[C_TX_RAW]      = is_tx && et_ip;
        o_upd.inc[C_TX_IGMP_RPT] = tx_first && (i_item.ip_proto == PR_IGMP) &&
                                   (i_item.igmp_type == i_igmp_rpt_type);
        o_upd.inc[C_TX_UDP]       = tx_first && (i_item.ip_proto == PR_UDP);
        o_upd.inc[C_TX_TCP]       = tx_tcp;
        o_upd.inc[C_TX_TCP_DATA]  = tx_tcp && has_data;
        o_upd.inc[C_TX_TCP_BYTES] = tx_tcp && has_data;
        // SYN, FIN or RST wins over a bare ACK.
        o_upd.inc[C_TX_TCP_CTRL]  = tx_tcp && (|flags[2:0]);
        o_upd.inc[C_TX_TCP_ACK]   = tx_tcp && !(|flags[2:0]) && flags[4];
        o_upd.inc[C_TX_TCP_URG]   = tx_tcp && flags[5];

        o_upd.byte_cnt  = i_item.ip_total_len - {9'd0, hdr_bytes};
        o_upd.hist_hit  = tx_first && (i_item.ip_proto == PR_ICMP);
        o_upd.icmp_type = i_item.icmp_type;
        o_upd.clear     = (i_item.kind == KIND_CLEAR);
    end

endmodule

// File: sv/psc_bank.sv
module psc_bank #(
    parameter int COUNTER_WIDTH = 32,
    parameter int HIST_DEPTH    = 19
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  psc_pkg::t_upd i_upd,
    input  logic [5:0]    i_rd_index,
    output logic [31:0]   o_rd_value
);
    import psc_pkg::*;

    logic [COUNTER_WIDTH-1:0] r_proto [NPROTO];
    logic [COUNTER_WIDTH-1:0] r_hist  [HIST_DEPTH];
    logic [COUNTER_WIDTH-1:0] rd_cnt;
    logic [5:0]               hist_off;

    // Each protocol counter has its own incrementer; the byte counter adds the payload length.
    for (genvar gi = 0; gi < NPROTO; gi++) begin : g_proto
        logic [COUNTER_WIDTH-1:0] amount;
        assign amount = (gi == C_TX_TCP_BYTES) ? COUNTER_WIDTH'(i_upd.byte_cnt)
                                               : COUNTER_WIDTH'(1);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_proto[gi] <= '0;
            end else if (i_en && i_upd.clear) begin
                r_proto[gi] <= '0;
            end else if (i_en && i_upd.inc[gi]) begin
                r_proto[gi] <= r_proto[gi] + amount;
            end
        end
    end

    // Transmit ICMP type histogram, one incrementer per type.
    for (genvar gh = 0; gh < HIST_DEPTH; gh++) begin : g_hist
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_hist[gh] <= '0;
            end else if (i_en && i_upd.clear) begin
                r_hist[gh] <= '0;
            end else if (i_en && i_upd.hist_hit && (i_upd.icmp_type == 8'(gh))) begin
                r_hist[gh] <= r_hist[gh] + COUNTER_WIDTH'(1);
            end
        end
    end

    // Read port: protocol bank below HIST_BASE, histogram above, zero beyond both.
    always_comb begin
        hist_off = i_rd_index - 6'(HIST_BASE);
        rd_cnt   = '0;
        if (i_rd_index < 6'(NPROTO)) begin
            rd_cnt = r_proto[i_rd_index[4:0]];
        end else begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                if (hist_off == 6'(i)) begin
                    rd_cnt = r_hist[i];
                end
            end
        end
        o_rd_value = 32'(64'(rd_cnt));
    end

`ifndef SYNTHESIS
    // A clear leaves both banks at zero.
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_upd.clear) |=> (r_proto[0] == '0 && r_proto[NPROTO-1] == '0 &&
                                   r_hist[0] == '0))
        else $error("counter bank not cleared");

    // An event counts in one direction only.
    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |-> !((|i_upd.inc[C_TX_BASE-1:0]) && (|i_upd.inc[NPROTO-1:C_TX_BASE])))
        else $error("receive and transmit counters bumped together");

    // An ARP request and reply are never counted for the same frame.
    a_arp_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |-> ($onehot0(i_upd.inc[C_RX_BASE+LK_ARP_REPLY:C_RX_BASE+LK_ARP_REQ]) &&
                  $onehot0(i_upd.inc[C_TX_BASE+LK_ARP_REPLY:C_TX_BASE+LK_ARP_REQ])))
        else $error("ARP request and reply both counted");
`endif

endmodule

// File: sv/packet_statistics_counters_core.sv
// Channel   Dir  Beat contents
// s_*       in   tuser: kind; tdata: event fields, see port comment
// m_*       out  tuser: is_read_reply; tdata: counter_value
// APB       in   rarp_enable @0x0, pppoe_enable @0x4, igmp_rpt_type @0x8
//
// One beat is taken per cycle while the result register can move on. A beat waits in the input
// register; as it moves on, the classifier and the counter bank update the counters it hits and
// the result register captures its result, which m_* then shows.
// Reset zeroes every counter at once and restores the register defaults.
// While m_tready is low the result holds and one more beat can wait in the input register.
module packet_statistics_counters_core #(
    parameter int ICMP_TYPES    = 19,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ethertype, arp_opcode, ip_proto, frag_offset, ip_hdr_words, ip_total_len,
    // icmp_type, igmp_type, tcp_data_offset, tcp_flags, counter_index, zero pad
    input  logic [111:0] s_tdata,
    // kind
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // counter_value
    output logic [31:0]  m_tdata,
    // is_read_reply
    output logic         m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import psc_pkg::*;

    localparam int HIST_READ  = READ_SPAN - HIST_BASE;
    localparam int HIST_DEPTH = (ICMP_TYPES < HIST_READ) ? ICMP_TYPES : HIST_READ;

    localparam logic [1:0] REG_RARP_EN   = 2'd0;
    localparam logic [1:0] REG_PPPOE_EN  = 2'd1;
    localparam logic [1:0] REG_IGMP_TYPE = 2'd2;

    logic        r_rarp_enable;
    logic        r_pppoe_enable;
    logic [7:0]  r_igmp_rpt_type;
    logic        cfg_wr;

    t_item       in_item;
    t_item       r_item;
    logic        r_in_valid;
    logic        n_in_valid;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [31:0] r_out_value;
    logic        r_out_read;
    logic        s_accept;
    logic        out_free;
    logic        advance;
    t_upd        upd;
    logic [31:0] rd_value;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rarp_enable   <= 1'b1;
            r_pppoe_enable  <= 1'b1;
            r_igmp_rpt_type <= 8'd18;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_RARP_EN:   r_rarp_enable   <= pwdata[0];
                REG_PPPOE_EN:  r_pppoe_enable  <= pwdata[0];
                REG_IGMP_TYPE: r_igmp_rpt_type <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RARP_EN:   prdata = {31'd0, r_rarp_enable};
            REG_PPPOE_EN:  prdata = {31'd0, r_pppoe_enable};
            REG_IGMP_TYPE: prdata = {24'd0, r_igmp_rpt_type};
            default:       prdata = '0;
        endcase
    end

    // Unpack the input beat.
    always_comb begin
        in_item.kind            = t_kind'(s_tuser);
        in_item.ethertype       = s_tdata[15:0];
        in_item.arp_opcode      = s_tdata[31:16];
        in_item.ip_proto        = s_tdata[39:32];
        in_item.frag_offset     = s_tdata[52:40];
        in_item.ip_hdr_words    = s_tdata[56:53];
        in_item.ip_total_len    = s_tdata[72:57];
        in_item.icmp_type       = s_tdata[80:73];
        in_item.igmp_type       = s_tdata[88:81];
        in_item.tcp_data_offset = s_tdata[92:89];
        in_item.tcp_flags       = s_tdata[100:93];
        in_item.counter_index   = s_tdata[106:101];
    end

    // Two-register pipeline: input register, then result register.
    always_comb begin
        out_free    = !r_out_valid || m_tready;
        advance     = r_in_valid && out_free;
        s_tready    = !r_in_valid || out_free;
        s_accept    = s_tvalid && s_tready;
        n_in_valid  = s_accept || (r_in_valid && !advance);
        n_out_valid = advance || (r_out_valid && !m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_item <= in_item;
        end
        if (advance) begin
            r_out_read  <= (r_item.kind == KIND_READ);
            r_out_value <= (r_item.kind == KIND_READ) ? rd_value : '0;
        end
    end

    psc_classify u_classify (
        .i_item          (r_item),
        .i_rarp_enable   (r_rarp_enable),
        .i_pppoe_enable  (r_pppoe_enable),
        .i_igmp_rpt_type (r_igmp_rpt_type),
        .o_upd           (upd)
    );

    psc_bank #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .HIST_DEPTH    (HIST_DEPTH)
    ) u_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_upd      (upd),
        .i_rd_index (r_item.counter_index),
        .o_rd_value (rd_value)
    );

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_value;
    assign m_tuser  = r_out_read;

`ifndef SYNTHESIS
    // Only read replies carry a counter value.
    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("non-read result carries data");

    // With the result register empty the input side never stalls.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_tready)
        else $error("input stalled with empty result register");

    // A write to the IGMP report register lands in the register on the clock edge of the access.
    a_igmp_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && paddr[3:2] == REG_IGMP_TYPE) |=> (r_igmp_rpt_type == $past(pwdata[7:0])))
        else $error("IGMP report type not written");
`endif

endmodule

// File: verif/psc_checker.sv
`timescale 1ns / 1ps

// Register indexes and reply layout shared by the checker and the test top.
package psc_test_pkg;

    localparam int REG_RARP_EN  = 0;
    localparam int REG_PPPOE_EN = 1;
    localparam int REG_IGMP_RPT = 2;

    localparam logic [7:0] IGMP_RPT_DEFAULT = 8'd18;

    // One output beat as the counter bank should produce it.
    typedef struct packed {
        logic [31:0] value;
        logic        reply;
    } t_reply;

endpackage

module psc_checker #(
    parameter int ICMP_TYPES = 19
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [111:0] i_s_tdata,
    input  logic [1:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [31:0]  i_m_tdata,
    input  logic         i_m_tuser,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [3:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    input  logic         i_pready,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_checked
);
    import psc_pkg::*;
    import psc_test_pkg::*;

    // Shadow copy of the counter bank and its registers.
    logic [31:0] proto_count [0:NPROTO-1];
    logic [31:0] icmp_tx_hist [0:ICMP_TYPES-1];
    logic        rarp_on;
    logic        pppoe_on;
    logic [7:0]  igmp_rpt;

    t_reply counter_replies [$];
    t_item  beat_in;
    t_reply want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic void bump(int idx, logic [31:0] amount);
        proto_count[idx] = proto_count[idx] + amount;
    endfunction

    function automatic void zero_bank();
        for (int i = 0; i < NPROTO; i++) proto_count[i] = '0;
        for (int i = 0; i < ICMP_TYPES; i++) icmp_tx_hist[i] = '0;
    endfunction

    // Link-level classification shared by both directions; returns 1 for IP frames.
    function automatic bit classify_link(int base, bit is_tx, logic [15:0] et,
                                         logic [15:0] op);
        if (et == ET_ARP) begin
            bump(base + LK_NONIP, 1);
            if (op == OP_ARP_REQ) bump(base + LK_ARP_REQ, 1);
            else if (op == OP_ARP_REPLY) bump(base + LK_ARP_REPLY, 1);
            return 0;
        end
        if (rarp_on && et == ET_RARP) begin
            bump(base + LK_NONIP, 1);
            if (op == OP_RARP_REQ) bump(base + LK_RARP_REQ, 1);
            else if (op == OP_RARP_REPLY) bump(base + LK_RARP_REPLY, 1);
            return 0;
        end
        if (pppoe_on && (et == ET_PPPOE_DISC || et == ET_PPPOE_SESS)) begin
            bump(base + ((et == ET_PPPOE_DISC) ? LK_PPPOE_DISC : LK_PPPOE_SESS), 1);
            if (!is_tx) bump(base + LK_NONIP, 1);
            return 0;
        end
        if (et != ET_IP) begin
            bump(base + LK_NONIP, 1);
            return 0;
        end
        return 1;
    endfunction

    // Applies one event to the shadow bank and returns the beat it should produce.
    function automatic t_reply apply_event(t_item ev);
        t_reply r;
        int     payload;
        int     idx;
        logic [5:0] fl;
        r = '0;
        case (ev.kind)
            KIND_RX: begin
                if (classify_link(C_RX_BASE, 0, ev.ethertype, ev.arp_opcode)) begin
                    bump(C_RX_IP, 1);
                    if (ev.ip_proto == PR_IGMP) bump(C_RX_IGMP, 1);
                    else if (ev.ip_proto == PR_UDP) bump(C_RX_UDP, 1);
                    else if (ev.ip_proto == PR_TCP) bump(C_RX_TCP, 1);
                end
            end
            KIND_TX: begin
                if (classify_link(C_TX_BASE, 1, ev.ethertype, ev.arp_opcode)) begin
                    bump(C_TX_RAW, 1);
                    // Only the first fragment carries the upper-layer header.
                    if (ev.frag_offset == '0) begin
                        if (ev.ip_proto == PR_ICMP) begin
                            if (int'(ev.icmp_type) < ICMP_TYPES)
                                icmp_tx_hist[ev.icmp_type] = icmp_tx_hist[ev.icmp_type] + 1;
                        end else if (ev.ip_proto == PR_IGMP) begin
                            if (ev.igmp_type == igmp_rpt) bump(C_TX_IGMP_RPT, 1);
                        end else if (ev.ip_proto == PR_UDP) begin
                            bump(C_TX_UDP, 1);
                        end else if (ev.ip_proto == PR_TCP) begin
                            fl = ev.tcp_flags[5:0];
                            payload = int'(ev.ip_total_len) - 4 * int'(ev.ip_hdr_words)
                                    - 4 * int'(ev.tcp_data_offset);
                            bump(C_TX_TCP, 1);
                            if (payload > 0) begin
                                bump(C_TX_TCP_DATA, 1);
                                bump(C_TX_TCP_BYTES, 32'(payload));
                            end
                            if (fl[2:0] != '0) bump(C_TX_TCP_CTRL, 1);
                            else if (fl[4]) bump(C_TX_TCP_ACK, 1);
                            if (fl[5]) bump(C_TX_TCP_URG, 1);
                        end
                    end
                end
            end
            KIND_READ: begin
                idx = int'(ev.counter_index);
                if (idx < NPROTO) r.value = proto_count[idx];
                else if (idx - HIST_BASE < ICMP_TYPES) r.value = icmp_tx_hist[idx - HIST_BASE];
                r.reply = 1'b1;
            end
            default: zero_bank();
        endcase
        return r;
    endfunction

    // Watch the register port, the output beats and the input beats, in that order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            zero_bank();
            rarp_on  = 1'b1;
            pppoe_on = 1'b1;
            igmp_rpt = IGMP_RPT_DEFAULT;
            counter_replies.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (int'(i_paddr[3:2]))
                    REG_RARP_EN:  rarp_on = i_pwdata[0];
                    REG_PPPOE_EN: pppoe_on = i_pwdata[0];
                    REG_IGMP_RPT: igmp_rpt = i_pwdata[7:0];
                    default: ;
                endcase
            end

            if (i_m_tvalid && i_m_tready) begin
                if (counter_replies.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("Unexpected output beat: value %h reply %b",
                                 i_m_tdata, i_m_tuser);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = counter_replies.pop_front();
                    if (want.value !== i_m_tdata || want.reply !== i_m_tuser) begin
                        if (o_fail_count < 10)
                            $display("Mismatch on beat %0d: expected value %h reply %b, got %h %b",
                                     o_checked, want.value, want.reply, i_m_tdata, i_m_tuser);
                        o_fail_count = o_fail_count + 1;
                    end
                    o_checked = o_checked + 1;
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                beat_in.kind            = t_kind'(i_s_tuser);
                beat_in.ethertype       = i_s_tdata[15:0];
                beat_in.arp_opcode      = i_s_tdata[31:16];
                beat_in.ip_proto        = i_s_tdata[39:32];
                beat_in.frag_offset     = i_s_tdata[52:40];
                beat_in.ip_hdr_words    = i_s_tdata[56:53];
                beat_in.ip_total_len    = i_s_tdata[72:57];
                beat_in.icmp_type       = i_s_tdata[80:73];
                beat_in.igmp_type       = i_s_tdata[88:81];
                beat_in.tcp_data_offset = i_s_tdata[92:89];
                beat_in.tcp_flags       = i_s_tdata[100:93];
                beat_in.counter_index   = i_s_tdata[106:101];
                counter_replies.push_back(apply_event(beat_in));
            end
        end
        o_pending = counter_replies.size();
    end

endmodule

// File: verif/packet_statistics_counters_core_test.sv
`timescale 1ns / 1ps

module packet_statistics_counters_core_test;

    import psc_pkg::*;
    import psc_test_pkg::*;

    localparam int ICMP_TYPES     = 19;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int BURST_EVENTS   = 10;
    localparam int RANDOM_EVENTS  = 55;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int fail_count;
    int pending;
    int checked;

    // Stimulus bookkeeping.
    bit         no_gaps;
    bit         hold_req;
    logic [7:0] cur_igmp;
    int         n_events;
    int         n_reads;
    int         n_clears;
    int         n_settings;
    int         quiet_cycles;

    packet_statistics_counters_core #(
        .ICMP_TYPES    (ICMP_TYPES),
        .COUNTER_WIDTH (32)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    psc_checker #(
        .ICMP_TYPES (ICMP_TYPES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic [111:0] pack_item(t_item it);
        return {5'd0, it.counter_index, it.tcp_flags, it.tcp_data_offset, it.igmp_type,
                it.icmp_type, it.ip_total_len, it.ip_hdr_words, it.frag_offset,
                it.ip_proto, it.arp_opcode, it.ethertype};
    endfunction

    function automatic t_item ev(t_kind kind, logic [15:0] et, logic [15:0] op,
                                 logic [7:0] proto, logic [12:0] frag, logic [3:0] hdr,
                                 logic [15:0] tlen, logic [7:0] icmp, logic [7:0] igmp,
                                 logic [3:0] doff, logic [7:0] flags);
        t_item it;
        it = '{kind, et, op, proto, frag, hdr, tlen, icmp, igmp, doff, flags, 6'd0};
        return it;
    endfunction

    // Mostly well-formed frames with random content; the rest is raw noise.
    function automatic t_item random_event();
        t_item it;
        int    r;
        it.kind            = t_kind'($urandom_range(0, 3));
        it.ethertype       = 16'($urandom);
        it.arp_opcode      = 16'($urandom);
        it.ip_proto        = 8'($urandom);
        it.frag_offset     = 13'($urandom);
        it.ip_hdr_words    = 4'($urandom);
        it.ip_total_len    = 16'($urandom);
        it.icmp_type       = 8'($urandom);
        it.igmp_type       = 8'($urandom);
        it.tcp_data_offset = 4'($urandom);
        it.tcp_flags       = 8'($urandom);
        it.counter_index   = 6'($urandom);
        r = $urandom_range(0, 99);
        if (r < 35) it.kind = KIND_RX;
        else if (r < 75) it.kind = KIND_TX;
        else if (r < 97) it.kind = KIND_READ;
        else it.kind = KIND_CLEAR;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: it.ethertype = ET_IP;
            5: it.ethertype = ET_ARP;
            6: it.ethertype = ET_RARP;
            7: it.ethertype = ET_PPPOE_DISC;
            8: it.ethertype = ET_PPPOE_SESS;
            default: ;
        endcase
        if ($urandom_range(0, 4) != 0) it.arp_opcode = 16'($urandom_range(0, 5));
        case ($urandom_range(0, 9))
            0, 1: it.ip_proto = PR_ICMP;
            2: it.ip_proto = PR_IGMP;
            3, 4, 5: it.ip_proto = PR_TCP;
            6, 7: it.ip_proto = PR_UDP;
            default: ;
        endcase
        if ($urandom_range(0, 9) < 7) it.frag_offset = '0;
        if ($urandom_range(0, 9) < 6) it.ip_hdr_words = 4'd5;
        if ($urandom_range(0, 1) == 0) it.ip_total_len = 16'($urandom_range(0, 200));
        if ($urandom_range(0, 9) < 7) it.icmp_type = 8'($urandom_range(0, 20));
        if ($urandom_range(0, 1) == 0) it.igmp_type = cur_igmp;
        if ($urandom_range(0, 9) < 6) it.tcp_data_offset = 4'd5;
        return it;
    endfunction

    // Offers one beat after a random gap (none while no_gaps is set) and returns at the falling edge after it moves.
    task automatic send_event(t_item it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_item(it);
        s_tuser  <= it.kind;
        do @(posedge i_clk); while (!(s_tvalid && s_tready));
        @(negedge i_clk);
        n_events = n_events + 1;
        if (it.kind == KIND_READ) n_reads = n_reads + 1;
        if (it.kind == KIND_CLEAR) n_clears = n_clears + 1;
    endtask

    task automatic read_counter(int idx);
        t_item it;
        it = ev(KIND_READ, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        it.counter_index = 6'(idx);
        send_event(it);
    endtask

    task automatic read_all_counters();
        for (int i = 0; i < 64; i++) read_counter(i);
    endtask

    // Stops offering and waits until every outstanding beat has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic apb_write(int idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx * 4);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(bit rarp, bit pppoe, logic [7:0] igmp);
        wait_drained();
        apb_write(REG_RARP_EN, {31'd0, rarp});
        apb_write(REG_PPPOE_EN, {31'd0, pppoe});
        apb_write(REG_IGMP_RPT, {24'd0, igmp});
        cur_igmp   = igmp;
        n_settings = n_settings + 1;
    endtask

    // Receiver: random stall per beat, or one long hold-off when asked.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, 11);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_tvalid && m_tready));
            @(negedge i_clk);
        end
    end

    // Watchdog on cycles in which no beat and no register access moves.
    initial quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles, %0d beats outstanding",
                     WATCHDOG_LIMIT, pending);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main stimulus.
    initial begin
        bit         rarp;
        bit         pppoe;
        logic [7:0] igmp;
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        no_gaps    = 1'b0;
        hold_req   = 1'b0;
        cur_igmp   = IGMP_RPT_DEFAULT;
        n_events   = 0;
        n_reads    = 0;
        n_clears   = 0;
        n_settings = 1;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed events with the reset register values.
        send_event(ev(KIND_RX, ET_ARP, OP_ARP_REQ, '0, '0, '0, '0, '0, '0, '0, '0));
        send_event(ev(KIND_TX, ET_ARP, OP_ARP_REPLY, '0, '0, '0, '0, '0, '0, '0, '0));
        send_event(ev(KIND_RX, ET_ARP, 16'hFFFF, '0, '0, '0, '0, '0, '0, '0, '0));
        send_event(ev(KIND_RX, ET_RARP, OP_RARP_REQ, '0, '0, '0, '0, '0, '0, '0, '0));
        send_event(ev(KIND_TX, ET_RARP, OP_RARP_REPLY, '0, '0, '0, '0, '0, '0, '0, '0));
        send_event(ev(KIND_TX, ET_RARP, OP_ARP_REQ, '0, '0, '0, '0, '0, '0, '0, '0));
        send_event(ev(KIND_RX, ET_PPPOE_DISC, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_event(ev(KIND_TX, ET_PPPOE_SESS, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_event(ev(KIND_RX, 16'hFFFF, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_event(ev(KIND_TX, 16'h0000, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_event(ev(KIND_RX, ET_IP, '0, PR_ICMP, '0, '0, '0, '0, '0, '0, '0));
        send_event(ev(KIND_RX, ET_IP, '0, PR_IGMP, '0, '0, '0, '0, '0, '0, '0));
        send_event(ev(KIND_RX, ET_IP, '0, PR_UDP, '0, '0, '0, '0, '0, '0, '0));
        send_event(ev(KIND_RX, ET_IP, '0, PR_TCP, '0, '0, '0, '0, '0, '0, '0));
        send_event(ev(KIND_RX, ET_IP, '0, 8'hFF, '0, '0, '0, '0, '0, '0, '0));
        send_event(ev(KIND_TX, ET_IP, '0, PR_ICMP, '0, '0, '0, 8'd0, '0, '0, '0));
        send_event(ev(KIND_TX, ET_IP, '0, PR_ICMP, '0, '0, '0, 8'(ICMP_TYPES - 1), '0, '0, '0));
        send_event(ev(KIND_TX, ET_IP, '0, PR_ICMP, '0, '0, '0, 8'(ICMP_TYPES), '0, '0, '0));
        send_event(ev(KIND_TX, ET_IP, '0, PR_ICMP, '0, '0, '0, 8'hFF, '0, '0, '0));
        send_event(ev(KIND_TX, ET_IP, '0, PR_IGMP, '0, '0, '0, '0, IGMP_RPT_DEFAULT, '0, '0));
        send_event(ev(KIND_TX, ET_IP, '0, PR_IGMP, '0, '0, '0, '0, 8'd0, '0, '0));
        send_event(ev(KIND_TX, ET_IP, '0, PR_UDP, 13'h1FFF, '0, '0, '0, '0, '0, '0));
        send_event(ev(KIND_TX, ET_IP, '0, PR_UDP, '0, '0, '0, '0, '0, '0, '0));
        // Full-length TCP with all flags, then zero, negative and positive payloads.
        send_event(ev(KIND_TX, ET_IP, '0, PR_TCP, '0, 4'hF, 16'hFFFF, '0, '0, 4'hF, 8'hFF));
        send_event(ev(KIND_TX, ET_IP, '0, PR_TCP, '0, 4'd5, 16'd40, '0, '0, 4'd5, 8'h10));
        send_event(ev(KIND_TX, ET_IP, '0, PR_TCP, '0, 4'd5, 16'd0, '0, '0, 4'd5, 8'h20));
        send_event(ev(KIND_TX, ET_IP, '0, PR_TCP, '0, 4'd5, 16'd100, '0, '0, 4'd5, 8'h12));
        send_event(ev(KIND_TX, ET_IP, '0, 8'd0, '0, '0, '0, '0, '0, '0, '0));
        read_all_counters();

        // A back-to-back burst of maximum payloads into the byte counter.
        send_event(ev(KIND_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        no_gaps = 1'b1;
        for (int i = 0; i < BURST_EVENTS; i++)
            send_event(ev(KIND_TX, ET_IP, '0, PR_TCP, '0, '0, 16'hFFFF, '0, '0, '0, 8'h00));
        no_gaps = 1'b0;
        read_counter(C_TX_TCP);
        read_counter(C_TX_TCP_DATA);
        read_counter(C_TX_TCP_BYTES);
        send_event(ev(KIND_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        read_counter(C_TX_TCP_BYTES);

        // Random phases over several register settings, extremes included.
        for (int s = 0; s < 4; s++) begin
            case (s)
                0: begin rarp = 1'b1; pppoe = 1'b1; igmp = IGMP_RPT_DEFAULT; end
                1: begin rarp = 1'b0; pppoe = 1'b0; igmp = 8'd0; end
                2: begin rarp = 1'b1; pppoe = 1'b0; igmp = 8'hFF; end
                default: begin rarp = 1'b0; pppoe = 1'b1; igmp = 8'($urandom); end
            endcase
            apply_setting(rarp, pppoe, igmp);

            // With both link options off, RARP and PPPoE fall back to plain non-IP.
            if (s == 1) begin
                send_event(ev(KIND_RX, ET_RARP, OP_RARP_REQ, '0, '0, '0, '0, '0, '0, '0, '0));
                send_event(ev(KIND_TX, ET_RARP, OP_RARP_REPLY, '0, '0, '0, '0, '0, '0, '0, '0));
                send_event(ev(KIND_RX, ET_PPPOE_DISC, '0, '0, '0, '0, '0, '0, '0, '0, '0));
                send_event(ev(KIND_TX, ET_PPPOE_SESS, '0, '0, '0, '0, '0, '0, '0, '0, '0));
                send_event(ev(KIND_TX, ET_IP, '0, PR_IGMP, '0, '0, '0, '0, 8'd0, '0, '0));
            end

            for (int i = 0; i < RANDOM_EVENTS; i++) begin
                if ($urandom_range(0, 29) == 0) no_gaps = !no_gaps;
                // Long receiver hold-off while the sender keeps offering.
                if (s == 2 && i == 30) hold_req = 1'b1;
                // Sender pause until the bank has answered everything.
                if (s == 3 && i == 50) wait_drained();
                send_event(random_event());
            end
            no_gaps = 1'b0;
        end
        read_all_counters();

        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("Summary: %0d events (%0d reads, %0d clears) under %0d register settings,",
                 n_events, n_reads, n_clears, n_settings);
        $display("         %0d output beats compared, %0d failures.", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
